// File: src/gcel_pkg.sv
`timescale 1ns / 1ps

package gcel_pkg;

    // default grid limits
    localparam int MAX_ROWS_DEF = 64;
    localparam int MAX_COLS_DEF = 64;

    // configuration register width and reset value
    localparam int                CFG_W     = 7;
    localparam logic [CFG_W-1:0]  DIM_RESET = 7'd64;

    // width of the reported row and column numbers
    localparam int IDX_W = 6;

    // depth of the queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // configuration register indexes
    typedef logic [0:0] cfg_index_t;
    localparam cfg_index_t REG_DATA_ROWS = 1'b0;
    localparam cfg_index_t REG_DATA_COLS = 1'b1;

    // role of one grid cell
    typedef enum logic [1:0] {
        KIND_DATA,
        KIND_ROW_CHECK,
        KIND_COL_CHECK,
        KIND_CORNER
    } item_kind_t;

    // classified cell as it travels from front to back
    typedef struct packed {
        item_kind_t             kind;
        logic [7:0]             data;
        logic [IDX_W-1:0]       row;
        logic [CFG_W-1:0]       col;
    } item_t;

endpackage

// File: src/gcel_front.sv
`timescale 1ns / 1ps

module gcel_front #(
    parameter int MAX_ROWS = gcel_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = gcel_pkg::MAX_COLS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  gcel_pkg::cfg_index_t      cfg_index,
    input  logic [gcel_pkg::CFG_W-1:0] cfg_data,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [7:0]                grid_byte,
    input  logic                      q_full,
    output logic                      push,
    output gcel_pkg::item_t           push_item
);
    import gcel_pkg::*;

    localparam int RPW = $clog2(MAX_ROWS + 1);
    localparam int CPW = $clog2(MAX_COLS + 1);

    logic [CFG_W-1:0] data_rows_reg;
    logic [CFG_W-1:0] data_cols_reg;
    logic [RPW-1:0]   row_pos_reg;
    logic [RPW-1:0]   row_pos_next;
    logic [CPW-1:0]   col_pos_reg;
    logic [CPW-1:0]   col_pos_next;
    logic [RPW-1:0]   rows_eff;
    logic [CPW-1:0]   cols_eff;
    item_kind_t       kind;

    // clamp the grid dimensions into range
    always_comb
    begin
        if (data_rows_reg == '0)
            rows_eff = RPW'(1);
        else if (int'(data_rows_reg) > MAX_ROWS)
            rows_eff = RPW'(MAX_ROWS);
        else
            rows_eff = RPW'(data_rows_reg);

        if (data_cols_reg == '0)
            cols_eff = CPW'(1);
        else if (int'(data_cols_reg) > MAX_COLS)
            cols_eff = CPW'(MAX_COLS);
        else
            cols_eff = CPW'(data_cols_reg);
    end

    // classify the cell from the grid position
    always_comb
    begin
        if (row_pos_reg < rows_eff)
        begin
            if (col_pos_reg < cols_eff)
            begin
                kind         = KIND_DATA;
                row_pos_next = row_pos_reg;
                col_pos_next = col_pos_reg + 1'b1;
            end
            else
            begin
                kind         = KIND_ROW_CHECK;
                row_pos_next = row_pos_reg + 1'b1;
                col_pos_next = '0;
            end
        end
        else if (col_pos_reg < cols_eff)
        begin
            kind         = KIND_COL_CHECK;
            row_pos_next = row_pos_reg;
            col_pos_next = col_pos_reg + 1'b1;
        end
        else
        begin
            kind         = KIND_CORNER;
            row_pos_next = '0;
            col_pos_next = '0;
        end
    end

    assign in_stall       = q_full;
    assign push           = in_valid && !q_full;
    assign push_item.kind = kind;
    assign push_item.data = grid_byte;
    assign push_item.row  = IDX_W'(row_pos_reg);
    assign push_item.col  = CFG_W'(col_pos_reg);

    // configuration registers and grid position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_rows_reg <= DIM_RESET;
            data_cols_reg <= DIM_RESET;
            row_pos_reg   <= '0;
            col_pos_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_DATA_ROWS: data_rows_reg <= cfg_data;
                    REG_DATA_COLS: data_cols_reg <= cfg_data;
                endcase
            end
            if (push)
            begin
                row_pos_reg <= row_pos_next;
                col_pos_reg <= col_pos_next;
            end
        end
    end

endmodule

// File: src/gcel_queue.sv
`timescale 1ns / 1ps

module gcel_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  gcel_pkg::item_t push_item,
    output logic            full,
    input  logic            pop,
    output logic            head_valid,
    output gcel_pkg::item_t head_item
);
    import gcel_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    item_t            slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full       = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_item  = slot_reg[rd_ptr_reg];

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_item;
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    // checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count above depth");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("push into full queue");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !head_valid |-> !pop)
        else $error("pop from empty queue");

endmodule

// File: src/gcel_back.sv
`timescale 1ns / 1ps

module gcel_back #(
    parameter int MAX_COLS = gcel_pkg::MAX_COLS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       head_valid,
    input  gcel_pkg::item_t            head_item,
    output logic                       pop,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic                       row_bad_found,
    output logic                       col_bad_found,
    output logic [gcel_pkg::IDX_W-1:0] bad_row_index,
    output logic [gcel_pkg::IDX_W-1:0] bad_col_index,
    output logic [7:0]                 stored_value,
    output logic [7:0]                 row_corrected_value,
    output logic [7:0]                 col_corrected_value
);
    import gcel_pkg::*;

    localparam int CIW      = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int RS_DEPTH = 2 ** (CIW + 1);

    // column sums and the two row banks
    logic [7:0] colsum_mem [MAX_COLS];
    logic [7:0] row_mem    [RS_DEPTH];

    // execute stage
    logic              b_valid_reg;
    item_t             b_item_reg;
    logic [7:0]        col_rd_reg;
    logic              fwd_reg;
    logic [7:0]        fwd_data_reg;
    logic              zero_reg;

    // stream state
    logic [MAX_COLS-1:0]  col_valid_reg;
    logic [7:0]           row_sum_reg;
    logic                 cur_bank_reg;
    logic                 bad_row_seen_reg;
    logic [IDX_W-1:0]     bad_row_num_reg;
    logic [7:0]           row_diff_reg;
    logic                 bad_col_seen_reg;
    logic [CIW-1:0]       bad_col_num_reg;
    logic [7:0]           col_diff_reg;

    // result register
    logic             o_valid_reg;
    logic             o_row_found_reg;
    logic             o_col_found_reg;
    logic [IDX_W-1:0] o_row_idx_reg;
    logic [IDX_W-1:0] o_col_idx_reg;
    logic [7:0]       o_row_diff_reg;
    logic [7:0]       o_col_diff_reg;
    logic [7:0]       rs_rd_reg;

    logic [CIW-1:0] b_col;
    logic [CIW-1:0] head_col;
    logic [7:0]     col_sum;
    logic [7:0]     new_sum;
    logic           b_hold;
    logic           b_fire;
    logic           data_fire;
    logic           row_fire;
    logic           col_fire;
    logic           corner_fire;
    logic           both_found;

    assign b_col    = CIW'(b_item_reg.col);
    assign head_col = CIW'(head_item.col);

    // column sum seen by the execute stage, with bypass of the last write
    assign col_sum = fwd_reg ? fwd_data_reg : (zero_reg ? 8'd0 : col_rd_reg);
    assign new_sum = col_sum + b_item_reg.data;

    // a corner waits only while an earlier result is still held
    assign b_hold      = b_valid_reg && (b_item_reg.kind == KIND_CORNER)
                         && o_valid_reg && out_stall;
    assign b_fire      = b_valid_reg && !b_hold;
    assign data_fire   = b_fire && (b_item_reg.kind == KIND_DATA);
    assign row_fire    = b_fire && (b_item_reg.kind == KIND_ROW_CHECK);
    assign col_fire    = b_fire && (b_item_reg.kind == KIND_COL_CHECK);
    assign corner_fire = b_fire && (b_item_reg.kind == KIND_CORNER);
    assign pop         = head_valid && !b_hold;

    // column sum memory: read on entry, write back on execute
    always_ff @(posedge clk)
    begin
        if (data_fire)
            colsum_mem[b_col] <= new_sum;
        if (pop)
            col_rd_reg <= colsum_mem[head_col];
    end

    // row banks: current row written, frozen bad row read at the corner
    always_ff @(posedge clk)
    begin
        if (data_fire)
            row_mem[{cur_bank_reg, b_col}] <= b_item_reg.data;
        if (corner_fire)
            rs_rd_reg <= row_mem[{~cur_bank_reg, bad_col_num_reg}];
    end

    // execute stage payload
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            b_item_reg   <= head_item;
            fwd_data_reg <= new_sum;
        end
    end

    // control and stream state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg      <= 1'b0;
            fwd_reg          <= 1'b0;
            zero_reg         <= 1'b1;
            col_valid_reg    <= '0;
            row_sum_reg      <= '0;
            cur_bank_reg     <= 1'b0;
            bad_row_seen_reg <= 1'b0;
            bad_row_num_reg  <= '0;
            row_diff_reg     <= '0;
            bad_col_seen_reg <= 1'b0;
            bad_col_num_reg  <= '0;
            col_diff_reg     <= '0;
            o_valid_reg      <= 1'b0;
            o_row_found_reg  <= 1'b0;
            o_col_found_reg  <= 1'b0;
            o_row_idx_reg    <= '0;
            o_col_idx_reg    <= '0;
            o_row_diff_reg   <= '0;
            o_col_diff_reg   <= '0;
        end
        else
        begin
            // stage advance and hazard flags for the incoming transaction
            if (pop)
            begin
                b_valid_reg <= 1'b1;
                fwd_reg     <= data_fire && (b_col == head_col);
                zero_reg    <= !col_valid_reg[head_col] || corner_fire;
            end
            else if (b_fire)
            begin
                b_valid_reg <= 1'b0;
            end

            // data cell
            if (data_fire)
            begin
                row_sum_reg          <= row_sum_reg + b_item_reg.data;
                col_valid_reg[b_col] <= 1'b1;
            end

            // row checksum: freeze the bank on the first mismatch
            if (row_fire)
            begin
                row_sum_reg <= '0;
                if (!bad_row_seen_reg && (row_sum_reg != b_item_reg.data))
                begin
                    bad_row_seen_reg <= 1'b1;
                    bad_row_num_reg  <= b_item_reg.row;
                    row_diff_reg     <= row_sum_reg - b_item_reg.data;
                    cur_bank_reg     <= ~cur_bank_reg;
                end
            end

            // column checksum
            if (col_fire)
            begin
                if (!bad_col_seen_reg && (col_sum != b_item_reg.data))
                begin
                    bad_col_seen_reg <= 1'b1;
                    bad_col_num_reg  <= b_col;
                    col_diff_reg     <= col_sum - b_item_reg.data;
                end
            end

            // corner: capture result and rearm
            if (corner_fire)
            begin
                o_row_found_reg  <= bad_row_seen_reg;
                o_col_found_reg  <= bad_col_seen_reg;
                o_row_idx_reg    <= bad_row_num_reg;
                o_col_idx_reg    <= IDX_W'(bad_col_num_reg);
                o_row_diff_reg   <= row_diff_reg;
                o_col_diff_reg   <= col_diff_reg;
                col_valid_reg    <= '0;
                row_sum_reg      <= '0;
                bad_row_seen_reg <= 1'b0;
                bad_row_num_reg  <= '0;
                row_diff_reg     <= '0;
                bad_col_seen_reg <= 1'b0;
                bad_col_num_reg  <= '0;
                col_diff_reg     <= '0;
            end

            // result handshake
            if (corner_fire)
                o_valid_reg <= 1'b1;
            else if (o_valid_reg && !out_stall)
                o_valid_reg <= 1'b0;
        end
    end

    // result fields; the stored and corrected values are zero where there is no crossing
    assign both_found          = o_row_found_reg && o_col_found_reg;
    assign out_valid           = o_valid_reg;
    assign row_bad_found       = o_row_found_reg;
    assign col_bad_found       = o_col_found_reg;
    assign bad_row_index       = o_row_idx_reg;
    assign bad_col_index       = o_col_idx_reg;
    assign stored_value        = both_found ? rs_rd_reg : 8'd0;
    assign row_corrected_value = both_found ? (rs_rd_reg - o_row_diff_reg) : 8'd0;
    assign col_corrected_value = both_found ? (rs_rd_reg - o_col_diff_reg) : 8'd0;

    // checks
    a_corner_result: assert property (@(posedge clk) disable iff (!rst_n)
        corner_fire |=> (o_valid_reg && !bad_row_seen_reg && !bad_col_seen_reg
                         && (row_sum_reg == 8'd0) && (col_valid_reg == '0)))
        else $error("corner did not post a result and rearm");

    a_hold_corner: assert property (@(posedge clk) disable iff (!rst_n)
        b_hold |-> ((b_item_reg.kind == KIND_CORNER) && o_valid_reg && !pop))
        else $error("execute stage held without a waiting result");

    a_row_seen_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(bad_row_seen_reg) |-> $past(row_fire))
        else $error("bad row flagged outside a row checksum");

endmodule

// File: src/grid_checksum_error_locator_top.sv
// Grid checksum error locator.
// Input channel (in_valid, in_stall, grid_byte) takes one grid cell per
// transaction in row-major order: data_rows rows of data_cols bytes, each
// followed by its mod-256 row checksum, then data_cols column checksums,
// then one corner byte. Only the corner byte produces a result transaction
// on the output channel (out_valid, out_stall and the result fields).
// Throughput is one cell per cycle while in_stall is low; the column sum
// read-modify-write loop sets it, with a bypass for back-to-back updates.
// After acceptance the corner byte passes through the queue, the execute
// stage and the result register, which drives out_valid.
// A four-entry queue parts the classifying front from the execute stage;
// in_stall rises only when that queue is full.
// While out_stall holds a result, later cells keep flowing until the next
// corner byte reaches the execute stage, which then waits for the output.
// Reset sets data_rows and data_cols to 64 and clears all running sums and
// flags at once; no clearing pass is needed. cfg_we writes data_rows (index 0)
// or data_cols (index 1); the user must write only while the block is idle (not enforced).
`timescale 1ns / 1ps

module grid_checksum_error_locator_top #(
    parameter int MAX_ROWS = gcel_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = gcel_pkg::MAX_COLS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  gcel_pkg::cfg_index_t       cfg_index,
    input  logic [gcel_pkg::CFG_W-1:0] cfg_data,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [7:0]                 grid_byte,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic                       row_bad_found,
    output logic                       col_bad_found,
    output logic [gcel_pkg::IDX_W-1:0] bad_row_index,
    output logic [gcel_pkg::IDX_W-1:0] bad_col_index,
    output logic [7:0]                 stored_value,
    output logic [7:0]                 row_corrected_value,
    output logic [7:0]                 col_corrected_value
);
    import gcel_pkg::*;

    logic  q_full;
    logic  push;
    item_t push_item;
    logic  pop;
    logic  head_valid;
    item_t head_item;

    // front: configuration and cell classification
    gcel_front #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .grid_byte (grid_byte),
        .q_full    (q_full),
        .push      (push),
        .push_item (push_item)
    );

    // queue between front and back
    gcel_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    // back: sums, checks and result
    gcel_back #(
        .MAX_COLS (MAX_COLS)
    ) u_back (
        .clk                 (clk),
        .rst_n               (rst_n),
        .head_valid          (head_valid),
        .head_item           (head_item),
        .pop                 (pop),
        .out_valid           (out_valid),
        .out_stall           (out_stall),
        .row_bad_found       (row_bad_found),
        .col_bad_found       (col_bad_found),
        .bad_row_index       (bad_row_index),
        .bad_col_index       (bad_col_index),
        .stored_value        (stored_value),
        .row_corrected_value (row_corrected_value),
        .col_corrected_value (col_corrected_value)
    );

endmodule
